/* rtl/caaf_pkg.sv */
// Shared types, constants and helpers for the coverage antialias pixel filter.
// Used by every module of the filter; depends on nothing.
`default_nettype none

package caaf_pkg;

    localparam int NB_COUNT = 6;   // neighbors per window
    localparam int CH_COUNT = 3;   // red, green, blue

    localparam logic [2:0]  FULL_COVER = 3'd7;
    localparam logic [10:0] FW_RESET   = 11'd320;
    localparam logic signed [13:0] ROUND_BIAS = 14'sd4;

    typedef logic [7:0] t_chan;

    // after unpack, pair compare and row multiply
    typedef struct packed {
        logic                                we;
        logic [2:0]                          k;
        logic [9:0]                          px;
        logic [19:0]                         yprod;
        logic [CH_COUNT-1:0][7:0]            ctr;
        logic [CH_COUNT-1:0][NB_COUNT-1:0][7:0] val;
        logic [CH_COUNT-1:0][NB_COUNT-1:0]   qhi;
        logic [CH_COUNT-1:0][NB_COUNT-1:0]   qlo;
    } t_s1;

    // after max/min selection and address add
    typedef struct packed {
        logic                     we;
        logic [2:0]               k;
        logic [19:0]              addr;
        logic [CH_COUNT-1:0][7:0] ctr;
        logic [CH_COUNT-1:0][7:0] hi;
        logic [CH_COUNT-1:0][7:0] lo;
    } t_s2;

    // after the weighted product
    typedef struct packed {
        logic                      we;
        logic [19:0]               addr;
        logic [CH_COUNT-1:0][7:0]  ctr;
        logic [CH_COUNT-1:0][13:0] prod;
    } t_s3;

    typedef struct packed {
        logic        we;
        logic [19:0] addr;
        logic [15:0] pixel;
    } t_res;

    // 5-bit channel to 8 bits by bit replication
    function automatic t_chan widen5(input logic [4:0] c);
        return {c, c[4:2]};
    endfunction

    // channel 0 is red (bits 14..10), 1 green, 2 blue
    function automatic logic [4:0] chan_bits(input logic [17:0] px, input int ch);
        return 5'(px >> (10 - 5 * ch));
    endfunction

endpackage

`default_nettype wire

/* rtl/caaf_front.sv */
// First stage: unpack pixels, neighbor coverage flags, pairwise qualifying
// compares per channel, and the row multiply of the address. Uses caaf_pkg.
`default_nettype none

module caaf_front (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [9:0]                          i_pos_x,
    input  wire logic [9:0]                          i_pos_y,
    input  wire logic [17:0]                         i_center,
    input  wire logic [caaf_pkg::NB_COUNT-1:0][17:0] i_nb,
    input  wire logic [10:0]                         i_frame_width,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output caaf_pkg::t_s1                            o_data
);
    import caaf_pkg::*;

    logic [NB_COUNT-1:0] w_full;
    t_s1                 n_data;
    t_s1                 r_data;
    logic                r_valid;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_data = '0;
        for (int i = 0; i < NB_COUNT; i++) begin
            w_full[i] = (i_nb[i][17:15] == FULL_COVER);
        end
        n_data.we    = (i_center[17:15] != FULL_COVER);
        n_data.k     = FULL_COVER - i_center[17:15];
        n_data.px    = i_pos_x;
        n_data.yprod = 20'({11'd0, i_pos_y} * {10'd0, i_frame_width});
        for (int ch = 0; ch < CH_COUNT; ch++) begin
            n_data.ctr[ch] = widen5(chan_bits(i_center, ch));
            for (int i = 0; i < NB_COUNT; i++) begin
                n_data.val[ch][i] = widen5(chan_bits(i_nb[i], ch));
            end
        end
        // a full neighbor counts for max when another full neighbor is >= it,
        // and for min when another full neighbor is <= it
        for (int ch = 0; ch < CH_COUNT; ch++) begin
            for (int i = 0; i < NB_COUNT; i++) begin
                for (int j = 0; j < NB_COUNT; j++) begin
                    if (j != i && w_full[i] && w_full[j]) begin
                        if (n_data.val[ch][j] >= n_data.val[ch][i]) begin
                            n_data.qhi[ch][i] = 1'b1;
                        end
                        if (n_data.val[ch][j] <= n_data.val[ch][i]) begin
                            n_data.qlo[ch][i] = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

/* rtl/caaf_select.sv */
// Second stage: per channel max and min over the qualifying neighbors,
// both seeded with the center, plus the column add of the address. Uses caaf_pkg.
`default_nettype none

module caaf_select (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire caaf_pkg::t_s1 i_data,
    output logic         o_valid,
    input  wire logic    i_ready,
    output caaf_pkg::t_s2 o_data
);
    import caaf_pkg::*;

    t_s2  n_data;
    t_s2  r_data;
    logic r_valid;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_data      = '0;
        n_data.we   = i_data.we;
        n_data.k    = i_data.k;
        n_data.addr = i_data.yprod + {10'd0, i_data.px};
        n_data.ctr  = i_data.ctr;
        for (int ch = 0; ch < CH_COUNT; ch++) begin
            n_data.hi[ch] = i_data.ctr[ch];
            n_data.lo[ch] = i_data.ctr[ch];
            for (int i = 0; i < NB_COUNT; i++) begin
                if (i_data.qhi[ch][i] && (i_data.val[ch][i] > n_data.hi[ch])) begin
                    n_data.hi[ch] = i_data.val[ch][i];
                end
                if (i_data.qlo[ch][i] && (i_data.val[ch][i] < n_data.lo[ch])) begin
                    n_data.lo[ch] = i_data.val[ch][i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

/* rtl/caaf_blend.sv */
// Third and fourth stages: weighted difference (7-cov)*(hi+lo-2*ctr)+4, then
// arithmetic shift, add to center, clamp and RGBA5551 pack. Uses caaf_pkg.
`default_nettype none

module caaf_blend (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire caaf_pkg::t_s2 i_data,
    output logic          o_valid,
    input  wire logic     i_ready,
    output caaf_pkg::t_res o_data
);
    import caaf_pkg::*;

    t_s3  n_s3;
    t_s3  r_s3;
    logic r_s3_valid;
    logic w_s3_ready;

    t_res n_res;
    t_res r_res;
    logic r_res_valid;
    logic w_res_ready;

    logic signed [CH_COUNT-1:0][10:0] w_diff;
    logic signed [13:0]               w_diff_x;
    logic signed [13:0]               w_k;
    logic signed [10:0]               w_step;
    logic signed [11:0]               w_sum;
    logic [CH_COUNT-1:0][7:0]         w_out;

    assign w_res_ready = !r_res_valid || i_ready;
    assign w_s3_ready  = !r_s3_valid || w_res_ready;
    assign o_ready     = w_s3_ready;

    // product stage
    always_comb begin
        n_s3      = '0;
        n_s3.we   = i_data.we;
        n_s3.addr = i_data.addr;
        n_s3.ctr  = i_data.ctr;
        w_k       = $signed({11'd0, i_data.k});
        w_diff_x  = '0;
        for (int ch = 0; ch < CH_COUNT; ch++) begin
            w_diff[ch] = $signed({3'd0, i_data.hi[ch]}) + $signed({3'd0, i_data.lo[ch]})
                       - $signed({2'd0, i_data.ctr[ch], 1'b0});
            // element select of a packed array is unsigned; restore the sign
            w_diff_x     = 14'($signed(w_diff[ch]));
            n_s3.prod[ch] = w_diff_x * w_k + ROUND_BIAS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_s3_ready) begin
            r_s3_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_s3_ready) begin
            r_s3 <= n_s3;
        end
    end

    // shift, add and pack stage
    always_comb begin
        w_step = '0;
        w_sum  = '0;
        for (int ch = 0; ch < CH_COUNT; ch++) begin
            w_step = 11'($signed(r_s3.prod[ch]) >>> 3);
            w_sum  = $signed({4'd0, r_s3.ctr[ch]}) + 12'(w_step);
            if (w_sum < 0) begin
                w_out[ch] = 8'd0;
            end else if (w_sum > 12'sd255) begin
                w_out[ch] = 8'd255;
            end else begin
                w_out[ch] = w_sum[7:0];
            end
        end
        n_res.we    = r_s3.we;
        n_res.addr  = r_s3.addr;
        // fully covered center is not written and carries a zero pixel
        n_res.pixel = r_s3.we ? {w_out[0][7:3], w_out[1][7:3], w_out[2][7:3], 1'b1} : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_res_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s3_valid && w_res_ready) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_res_valid;
    assign o_data  = r_res;

endmodule

`default_nettype wire

/* rtl/coverage_antialias_pixel_filter_top.sv */
// Pipeline: four register stages; a result passes the front, select, product and
// pack registers in order, and is held there while the output side is not ready.
// Throughput: one transaction per cycle; each stage has its own valid bit and
// advances whenever the stage after it is empty or draining.
// Reset: synchronous active low; clears all stage valid bits, frame_width = 320.
// Top level: config register and the front/select/blend pipeline. Uses caaf_pkg.
`default_nettype none

module coverage_antialias_pixel_filter_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [10:0] i_cfg_wr_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [9:0]  i_pos_x,
    input  wire logic [9:0]  i_pos_y,
    input  wire logic [17:0] i_center_pixel,
    input  wire logic [17:0] i_above_left,
    input  wire logic [17:0] i_above_right,
    input  wire logic [17:0] i_far_left,
    input  wire logic [17:0] i_far_right,
    input  wire logic [17:0] i_below_left,
    input  wire logic [17:0] i_below_right,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_write_enable,
    output logic [19:0]      o_write_address,
    output logic [15:0]      o_filtered_pixel
);
    import caaf_pkg::*;

    logic [10:0]               r_frame_width;
    logic [NB_COUNT-1:0][17:0] w_nb;

    t_s1  w_s1;
    logic w_s1_valid;
    logic w_s1_ready;
    t_s2  w_s2;
    logic w_s2_valid;
    logic w_s2_ready;
    t_res w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width <= FW_RESET;
        end else if (i_cfg_wr_en) begin
            r_frame_width <= i_cfg_wr_data;
        end
    end

    assign w_nb = {i_below_right, i_below_left, i_far_right, i_far_left,
                   i_above_right, i_above_left};

    caaf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_center      (i_center_pixel),
        .i_nb          (w_nb),
        .i_frame_width (r_frame_width),
        .o_valid       (w_s1_valid),
        .i_ready       (w_s1_ready),
        .o_data        (w_s1)
    );

    caaf_select u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s1_valid),
        .o_ready (w_s1_ready),
        .i_data  (w_s1),
        .o_valid (w_s2_valid),
        .i_ready (w_s2_ready),
        .o_data  (w_s2)
    );

    caaf_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s2_valid),
        .o_ready (w_s2_ready),
        .i_data  (w_s2),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (w_res)
    );

    assign o_write_enable   = w_res.we;
    assign o_write_address  = w_res.addr;
    assign o_filtered_pixel = w_res.pixel;

endmodule

`default_nettype wire

/* rtl/caaf_checker.sv */
// Port-level checks for the coverage antialias pixel filter, bound to the top.
// Depends only on the top level's ports.
`default_nettype none

module caaf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic        o_write_enable,
    input wire logic [19:0] o_write_address,
    input wire logic [15:0] o_filtered_pixel
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_write_address)
            && $stable(o_filtered_pixel) && $stable(o_write_enable))
        else $error("stalled result changed");

    // no result can be pending right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // skipped write carries a zero pixel
    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_write_enable |-> o_filtered_pixel == 16'd0)
        else $error("non-zero pixel on skipped write");

    // written pixel is opaque
    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_write_enable |-> o_filtered_pixel[0])
        else $error("alpha bit clear on write");

    // with the output draining, the pipeline never refuses input
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready)
        else $error("input refused while output drains");

endmodule

bind coverage_antialias_pixel_filter_top caaf_checker u_caaf_checker (.*);

`default_nettype wire
